### rtl/core/dpq_pkg.sv
// Types, codes and the ranking function of the deadline priority queue.
// No dependencies; used by dpq_cell and deadline_priority_queue.
`timescale 1ns / 1ps

package dpq_pkg;

    localparam int PRI_W  = 8;
    localparam int TIME_W = 32;
    localparam int PAY_W  = 32;
    localparam int STAT_W = 2;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] deadline;
        logic [PAY_W-1:0]  payload;
    } entry_t;

    // what a cell loads on the next edge
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD_NEW,
        OP_FROM_LEFT,
        OP_FROM_RIGHT
    } cell_op_t;

    // compare results a cell reports to the controller
    typedef struct packed {
        logic beats;  // new word strictly outranks this cell's entry
        logic live;   // this cell's deadline lies after the current time
    } cell_flags_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_APPLY
    } state_t;

    // higher priority first, then later deadline
    function automatic logic outranks(input entry_t a, input entry_t b);
        logic res;
        if (a.pri != b.pri) begin
            res = (a.pri > b.pri);
        end else begin
            res = (a.deadline > b.deadline);
        end
        return res;
    endfunction

endpackage

### rtl/core/deadline_priority_queue.sv
// Top level of the deadline priority queue: command register, controller,
// chain of dpq_cell slots and result register. Uses dpq_pkg and dpq_cell.
`timescale 1ns / 1ps

// Deadline priority queue. Holds up to CAPACITY entries (priority, deadline,
// payload) in a row of cells, kept sorted best first: higher priority, then
// later deadline; equal ranks leave in arrival order. A push word (s_cmd = 0)
// inserts its entry, or reports full and drops it. A pop word (s_cmd = 1)
// returns the first entry whose deadline is after s_current_time and closes
// the gap; expired entries ahead of it stay put. If no stored entry qualifies,
// the pop empties the store and reports status 2. Every input word yields
// exactly one result word; push results carry zero entry fields.
// Timing: a word is accepted in the idle state, every cell compares against
// it in the next cycle (flags registered), and in the apply state after that
// the chain shifts in one step and the result lands in the output register.
// A new word is taken only once the last has been applied; a result that is
// not taken holds the next word in its apply cycle. The next input word is
// taken while a result still waits in the output register. Stored entries are
// not cleared at reset; of the store, only the occupancy count is.
module deadline_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [dpq_pkg::PRI_W-1:0]   s_new_priority,
    input  logic [dpq_pkg::TIME_W-1:0]  s_new_deadline,
    input  logic [dpq_pkg::PAY_W-1:0]   s_new_payload,
    input  logic [dpq_pkg::TIME_W-1:0]  s_current_time,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dpq_pkg::STAT_W-1:0]  m_status,
    output logic [dpq_pkg::PRI_W-1:0]   m_out_priority,
    output logic [dpq_pkg::TIME_W-1:0]  m_out_deadline,
    output logic [dpq_pkg::PAY_W-1:0]   m_out_payload
);
    import dpq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    // controller
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   mark_en;
    logic   apply_go;

    // latched command word
    logic                cmd_reg;
    entry_t              cmd_entry_reg;
    logic [TIME_W-1:0]   cmd_time_reg;

    // fill count
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    // per-cell compare results, registered in the mark cycle
    logic [CAPACITY-1:0] beats_reg;
    logic [CAPACITY-1:0] hit_reg;

    // chain wiring
    entry_t              cell_entry [CAPACITY];
    cell_flags_t         cell_flags [CAPACITY];
    cell_op_t            cell_op    [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;

    // pop selection
    logic [CAPACITY-1:0] hit_neg;
    logic [CAPACITY-1:0] hit_first;
    logic [CAPACITY-1:0] hit_from;
    entry_t              pop_entry;

    logic                is_push;
    logic                is_full;
    logic                no_hit;

    // result register
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STAT_W-1:0]   m_status_reg;
    logic [STAT_W-1:0]   m_status_next;
    entry_t              m_entry_reg;
    entry_t              m_entry_next;

    // ---------------------------------------------------------------
    // Controller: idle -> mark (cells compare) -> apply (chain moves)
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_MARK;
            S_MARK:  state_next = S_APPLY;
            S_APPLY: if (apply_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == S_IDLE);
        mark_en  = (state_reg == S_MARK);
        apply_go = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command word; payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg                <= s_cmd;
            cmd_entry_reg.pri      <= s_new_priority;
            cmd_entry_reg.deadline <= s_new_deadline;
            cmd_entry_reg.payload  <= s_new_payload;
            cmd_time_reg           <= s_current_time;
        end
    end

    // ---------------------------------------------------------------
    // Cell chain. A slot past the fill count counts as beaten by any
    // push and never as live for a pop. Since the store is sorted,
    // beats is monotonic along the chain: the insert point is where it
    // first goes high.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        entry_t left_in;
        entry_t right_in;

        if (g == 0) begin : g_head
            assign left_in = cmd_entry_reg;
        end else begin : g_mid_l
            assign left_in = cell_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_in = cell_entry[g];
        end else begin : g_mid_r
            assign right_in = cell_entry[g+1];
        end

        assign cell_valid[g] = (occ_reg > OCC_W'(g));

        dpq_cell u_cell (
            .aclk         (aclk),
            .op           (cell_op[g]),
            .new_entry    (cmd_entry_reg),
            .current_time (cmd_time_reg),
            .left_entry   (left_in),
            .right_entry  (right_in),
            .entry_q      (cell_entry[g]),
            .flags        (cell_flags[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (mark_en) begin
            for (int i = 0; i < CAPACITY; i++) begin
                beats_reg[i] <= cell_flags[i].beats || !cell_valid[i];
                hit_reg[i]   <= cell_flags[i].live && cell_valid[i];
            end
        end
    end

    // lowest live slot and everything from it upward, from one negation
    assign hit_neg   = ~hit_reg + {{(CAPACITY-1){1'b0}}, 1'b1};
    assign hit_first = hit_reg & hit_neg;
    assign hit_from  = hit_reg | hit_neg;

    always_comb begin
        pop_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit_first[i]) begin
                pop_entry = pop_entry | cell_entry[i];
            end
        end
    end

    assign is_push = (cmd_reg == CMD_PUSH);
    assign is_full = (occ_reg == OCC_W'(CAPACITY));
    assign no_hit  = (hit_reg == '0);

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_op[i] = OP_HOLD;
            if (apply_go) begin
                if (is_push) begin
                    if (!is_full && beats_reg[i]) begin
                        if (i == 0) begin
                            cell_op[i] = OP_LOAD_NEW;
                        end else if (beats_reg[(i == 0) ? 0 : i-1]) begin
                            cell_op[i] = OP_FROM_LEFT;
                        end else begin
                            cell_op[i] = OP_LOAD_NEW;
                        end
                    end
                end else if (hit_from[i] && !no_hit) begin
                    cell_op[i] = OP_FROM_RIGHT;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Fill count and result
    // ---------------------------------------------------------------
    always_comb begin
        occ_next      = occ_reg;
        m_status_next = STAT_OK;
        m_entry_next  = '0;
        if (is_push) begin
            if (is_full) begin
                m_status_next = STAT_FULL;
            end else begin
                occ_next = occ_reg + 1'b1;
            end
        end else if (no_hit) begin
            occ_next      = '0;
            m_status_next = STAT_EMPTY;
        end else begin
            occ_next     = occ_reg - 1'b1;
            m_entry_next = pop_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (apply_go) begin
            occ_reg <= occ_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (apply_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            m_status_reg <= m_status_next;
            m_entry_reg  <= m_entry_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_priority = m_entry_reg.pri;
    assign m_out_deadline = m_entry_reg.deadline;
    assign m_out_payload  = m_entry_reg.payload;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply_go && is_push && is_full) |=> (occ_reg == $past(occ_reg)))
        else $error("dropped push changed occupancy");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result raised outside apply");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STAT_OK) |->
            (m_entry_reg.pri == '0 && m_entry_reg.deadline == '0 &&
             m_entry_reg.payload == '0))
        else $error("non-ok result carries entry fields");

endmodule

### rtl/core/dpq_cell.sv
// One slot of the sorted chain: holds an entry, compares it against the
// incoming word and loads from itself, the new word or a neighbour. Uses dpq_pkg.
`timescale 1ns / 1ps

module dpq_cell (
    input  logic                    aclk,
    input  dpq_pkg::cell_op_t       op,
    input  dpq_pkg::entry_t         new_entry,
    input  logic [dpq_pkg::TIME_W-1:0] current_time,
    input  dpq_pkg::entry_t         left_entry,
    input  dpq_pkg::entry_t         right_entry,
    output dpq_pkg::entry_t         entry_q,
    output dpq_pkg::cell_flags_t    flags
);
    import dpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        case (op)
            OP_HOLD:       entry_next = entry_reg;
            OP_LOAD_NEW:   entry_next = new_entry;
            OP_FROM_LEFT:  entry_next = left_entry;
            OP_FROM_RIGHT: entry_next = right_entry;
            default:       entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q     = entry_reg;
    assign flags.beats = outranks(new_entry, entry_reg);
    assign flags.live  = (entry_reg.deadline > current_time);

endmodule
